>>> rtl/zbs_pkg.sv
`default_nettype none

package zbs_pkg;

   localparam int GROUP_SIZE = 8;
   localparam int IDX_W = $clog2(GROUP_SIZE);
   localparam int CNT_W = IDX_W + 1;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [7:0] TOP_BIT = 8'h80;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIRECTION       = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SUPPRESSED_BYTE = 1'b1;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       stream_end;
   } rsp_type;

   // one queued job: optional head byte, then body bytes or repeated markers
   typedef struct packed {
      logic [7:0]                  head_byte;
      logic                        head_valid;
      logic [GROUP_SIZE-1:0][7:0]  body;
      logic [CNT_W-1:0]            body_count;
      logic                        body_marker;
      logic                        stream_last;
   } cmd_type;

   function automatic logic [CNT_W-1:0] lead_ones(input logic [GROUP_SIZE-1:0] v);
      logic [CNT_W-1:0] n;
      logic             run;
      n   = '0;
      run = 1'b1;
      for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
         if (run && v[i]) begin
            n = n + CNT_W'(1);
         end else begin
            run = 1'b0;
         end
      end
      return n;
   endfunction

   function automatic logic [CNT_W-1:0] count_ones(input logic [GROUP_SIZE-1:0] v);
      logic [CNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < GROUP_SIZE; i++) begin
         n = n + CNT_W'(v[i]);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

>>> rtl/zbs_front.sv
`default_nettype none

module zbs_front import zbs_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       clear,
   input  wire logic       direction,
   input  wire logic [7:0] suppressed_byte,
   input  wire logic       accept,
   input  wire req_type    req_data,
   output logic            push,
   output cmd_type         push_cmd
);

   logic [GROUP_SIZE-1:0]      flag_ff, flag_in;
   logic [CNT_W-1:0]           pos_ff, pos_in;
   logic [CNT_W-1:0]           kept_ff, kept_in;
   logic                       awaiting_ff, awaiting_in;
   logic [GROUP_SIZE-1:0][7:0] group_ff, group_in;

   logic                  match;
   logic [GROUP_SIZE-1:0] enc_flag;
   logic [CNT_W-1:0]      enc_pos;
   logic [GROUP_SIZE-1:0] dec_flag;
   logic [CNT_W-1:0]      dec_pos;
   logic                  has_data;
   logic [CNT_W-1:0]      lead;
   logic [CNT_W-1:0]      markers;
   logic [GROUP_SIZE-1:0] dec_flag_rest;
   logic [CNT_W-1:0]      dec_pos_rest;
   logic                  done;

   always_comb begin
      flag_in     = flag_ff;
      pos_in      = pos_ff;
      kept_in     = kept_ff;
      awaiting_in = awaiting_ff;
      group_in    = group_ff;
      push        = 1'b0;
      push_cmd    = '0;
      done        = 1'b0;

      match    = req_data.data_byte == suppressed_byte;
      enc_flag = flag_ff | (match ? (TOP_BIT >> pos_ff[IDX_W-1:0]) : '0);
      enc_pos  = pos_ff + CNT_W'(1);

      if (awaiting_ff) begin
         dec_flag = req_data.data_byte;
         dec_pos  = '0;
         has_data = 1'b0;
      end else begin
         dec_flag = flag_ff << 1;
         dec_pos  = pos_ff + CNT_W'(1);
         has_data = 1'b1;
      end
      lead          = lead_ones(dec_flag);
      markers       = req_data.stream_last ? count_ones(dec_flag) : lead;
      dec_flag_rest = dec_flag << lead;
      dec_pos_rest  = dec_pos + lead;

      if (accept) begin
         if (direction == DIR_ENCODE) begin
            if (!match) begin
               group_in[kept_ff[IDX_W-1:0]] = req_data.data_byte;
               kept_in = kept_ff + CNT_W'(1);
            end
            flag_in = enc_flag;
            pos_in  = enc_pos;
            done    = (enc_pos >= CNT_W'(GROUP_SIZE)) || req_data.stream_last;
            if (done) begin
               push                 = 1'b1;
               push_cmd.head_byte   = enc_flag;
               push_cmd.head_valid  = 1'b1;
               push_cmd.body        = group_in;
               push_cmd.body_count  = kept_in;
               push_cmd.body_marker = 1'b0;
               push_cmd.stream_last = req_data.stream_last;
            end
         end else begin
            push                 = has_data || (markers != '0);
            push_cmd.head_byte   = req_data.data_byte;
            push_cmd.head_valid  = has_data;
            push_cmd.body_count  = markers;
            push_cmd.body_marker = 1'b1;
            push_cmd.stream_last = req_data.stream_last;
            flag_in     = dec_flag_rest;
            pos_in      = dec_pos_rest;
            awaiting_in = 1'b0;
            done        = (dec_pos_rest >= CNT_W'(GROUP_SIZE)) || req_data.stream_last;
         end
         if (done) begin
            flag_in     = '0;
            pos_in      = '0;
            kept_in     = '0;
            awaiting_in = 1'b1;
         end
      end

      if (clear) begin
         flag_in     = '0;
         pos_in      = '0;
         kept_in     = '0;
         awaiting_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff     <= '0;
         pos_ff      <= '0;
         kept_ff     <= '0;
         awaiting_ff <= 1'b1;
      end else begin
         flag_ff     <= flag_in;
         pos_ff      <= pos_in;
         kept_ff     <= kept_in;
         awaiting_ff <= awaiting_in;
      end
   end

   always_ff @(posedge clock) begin
      group_ff <= group_in;
   end

endmodule

`default_nettype wire

>>> rtl/zbs_queue.sv
`default_nettype none

module zbs_queue import zbs_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output logic         full,
   output logic         head_valid,
   output cmd_type      head_cmd
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   assign full       = count_ff == COUNT_W'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

>>> rtl/zbs_back.sv
`default_nettype none

module zbs_back import zbs_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [7:0] suppressed_byte,
   input  wire logic       cmd_valid,
   input  wire cmd_type    cmd,
   output logic            pop,
   output logic            rsp_valid,
   output rsp_type         rsp_data,
   input  wire logic       rsp_stall
);

   logic [CNT_W-1:0] step_ff, step_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic             load;
   logic             emit;
   logic [CNT_W-1:0] total;
   logic [CNT_W-1:0] body_idx;
   logic             final_step;
   logic [7:0]       out_byte;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      load       = !rsp_valid_ff || !rsp_stall;
      emit       = cmd_valid && load;
      total      = cmd.body_count + CNT_W'(cmd.head_valid);
      final_step = step_ff == (total - CNT_W'(1));
      body_idx   = step_ff - CNT_W'(cmd.head_valid);
      if (cmd.head_valid && step_ff == '0) begin
         out_byte = cmd.head_byte;
      end else if (cmd.body_marker) begin
         out_byte = suppressed_byte;
      end else begin
         out_byte = cmd.body[body_idx[IDX_W-1:0]];
      end

      pop          = emit && final_step;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         rsp_data_in.out_byte   = out_byte;
         rsp_data_in.run_last   = final_step;
         rsp_data_in.stream_end = final_step && cmd.stream_last;
         step_in = final_step ? '0 : step_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

>>> rtl/zero_byte_suppression_codec_unit.sv
// path: the first result of an item is held in a job queue entry, then in the output register
// throughput: one input byte per cycle while the job queue has room; one result per cycle
// out while rsp_stall is low, and an item can cause up to nine results
// reset: synchronous, clears queue, group state and output valid; encode mode, marker zero
`default_nettype none

module zero_byte_suppression_codec_unit import zbs_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic       direction_ff, direction_in;
   logic [7:0] suppressed_byte_ff, suppressed_byte_in;
   logic       clear;

   logic    accept;
   logic    push;
   cmd_type push_cmd;
   logic    pop;
   logic    full;
   logic    head_valid;
   cmd_type head_cmd;

   always_comb begin
      direction_in       = direction_ff;
      suppressed_byte_in = suppressed_byte_ff;
      clear              = 1'b0;
      if (csr_write_en) begin
         case (csr_index)
            CSR_DIRECTION: begin
               direction_in = csr_wdata[0];
               clear        = 1'b1;
            end
            CSR_SUPPRESSED_BYTE: begin
               suppressed_byte_in = csr_wdata[7:0];
            end
            default: begin
               direction_in = direction_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff       <= DIR_ENCODE;
         suppressed_byte_ff <= '0;
      end else begin
         direction_ff       <= direction_in;
         suppressed_byte_ff <= suppressed_byte_in;
      end
   end

   assign req_stall = full;
   assign accept    = req_valid && !full;

   zbs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .clear           (clear),
      .direction       (direction_ff),
      .suppressed_byte (suppressed_byte_ff),
      .accept          (accept),
      .req_data        (req_data),
      .push            (push),
      .push_cmd        (push_cmd)
   );

   zbs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   zbs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .suppressed_byte (suppressed_byte_ff),
      .cmd_valid       (head_valid),
      .cmd             (head_cmd),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data),
      .rsp_stall       (rsp_stall)
   );

endmodule

`default_nettype wire

>>> tb/sv/zbs_result_checker.sv
`default_nettype none

module zbs_result_checker import zbs_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire req_type                req_data,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire rsp_type                rsp_data,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   end_check,
   output int                          failures,
   output int                          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   logic       codec_mode;
   logic [7:0] marker_byte;
   logic [7:0] group_bytes [GROUP_SIZE];
   logic [7:0] flag_bits;
   logic [3:0] bit_pos;
   logic [3:0] kept_cnt;
   logic       awaiting_flag;
   logic [7:0] burst_bytes [GROUP_SIZE+1];
   int         burst_len;
   rsp_type    expected_bytes [$];
   rsp_type    want;
   logic       leftover_seen;

   task automatic restart_group();
      flag_bits     = '0;
      bit_pos       = '0;
      kept_cnt      = '0;
      awaiting_flag = 1'b1;
   endtask

   task automatic queue_byte(input logic [7:0] value);
      if (burst_len < GROUP_SIZE + 1) begin
         burst_bytes[burst_len] = value;
         burst_len++;
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $time, what);
      failures++;
   endtask

   task automatic predict_transfer(input req_type item);
      rsp_type r;
      logic    stop;
      burst_len = 0;
      if (codec_mode == DIR_ENCODE) begin
         if (bit_pos >= GROUP_SIZE) begin
            restart_group();
         end
         if (item.data_byte == marker_byte) begin
            flag_bits = flag_bits | (TOP_BIT >> bit_pos);
         end else if (kept_cnt < GROUP_SIZE) begin
            group_bytes[kept_cnt] = item.data_byte;
            kept_cnt++;
         end
         bit_pos++;
         if (bit_pos >= GROUP_SIZE || item.stream_last) begin
            queue_byte(flag_bits);
            for (int k = 0; k < kept_cnt; k++) begin
               queue_byte(group_bytes[k]);
            end
            restart_group();
         end
      end else begin
         if (awaiting_flag) begin
            flag_bits     = item.data_byte;
            bit_pos       = '0;
            awaiting_flag = 1'b0;
         end else begin
            queue_byte(item.data_byte);
            flag_bits = flag_bits << 1;
            bit_pos++;
         end
         // leading ones become markers; at stream end the zeros are skipped too
         stop = 1'b0;
         while (bit_pos < GROUP_SIZE && !stop) begin
            if (flag_bits[7]) begin
               queue_byte(marker_byte);
            end else if (!item.stream_last) begin
               stop = 1'b1;
            end
            if (!stop) begin
               flag_bits = flag_bits << 1;
               bit_pos++;
            end
         end
         if (bit_pos >= GROUP_SIZE || item.stream_last) begin
            restart_group();
         end
      end
      for (int i = 0; i < burst_len; i++) begin
         r.out_byte   = burst_bytes[i];
         r.run_last   = (i == burst_len - 1);
         r.stream_end = r.run_last & item.stream_last;
         expected_bytes.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         failures    = 0;
         codec_mode  = DIR_ENCODE;
         marker_byte = '0;
         for (int i = 0; i < GROUP_SIZE; i++) begin
            group_bytes[i] = '0;
         end
         restart_group();
         expected_bytes.delete();
         leftover_seen = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("result transfer %02h with nothing expected",
                                         rsp_data.out_byte));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_data.out_byte !== want.out_byte ||
                   rsp_data.run_last !== want.run_last ||
                   rsp_data.stream_end !== want.stream_end) begin
                  report_mismatch($sformatf(
                     "byte %02h run_last %b stream_end %b, expected %02h %b %b",
                     rsp_data.out_byte, rsp_data.run_last, rsp_data.stream_end,
                     want.out_byte, want.run_last, want.stream_end));
               end
            end
         end
         if (csr_write_en) begin
            if (csr_index == CSR_DIRECTION) begin
               codec_mode = csr_wdata[0];
               restart_group();
            end else if (csr_index == CSR_SUPPRESSED_BYTE) begin
               marker_byte = csr_wdata;
            end
         end
         if (req_valid && !req_stall) begin
            predict_transfer(req_data);
         end
         if (end_check && !leftover_seen) begin
            leftover_seen = 1'b1;
            if (expected_bytes.size() != 0) begin
               report_mismatch($sformatf("%0d expected results never arrived",
                                         expected_bytes.size()));
            end
         end
      end
      outstanding <= expected_bytes.size();
   end

endmodule

`default_nettype wire

>>> tb/sv/zero_byte_suppression_codec_unit_tb.sv
`default_nettype none

module zero_byte_suppression_codec_unit_tb import zbs_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 16;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_data;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   end_check;

   int check_failures;
   int pending_results;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int sent_count    = 0;
   int quiet_cycles  = 0;
   int idle_mix  [4] = '{0, 84, 0, 7};
   int stall_mix [4] = '{0, 0, 84, 7};

   logic [7:0] dense_group [8] = '{8'hFF, 8'h01, 8'h80, 8'h7F, 8'hAA, 8'h55, 8'hFE, 8'h02};
   logic       mode;
   logic [7:0] mk;
   logic [7:0] flag;
   logic       closing;
   int         phase_end;
   int         len;
   int         groups;
   int         zeros;
   int         data_n;

   zero_byte_suppression_codec_unit DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   zbs_result_checker result_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .end_check    (end_check),
      .failures     (check_failures),
      .outstanding  (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** zero_byte_suppression_codec_unit: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic [7:0] value, input logic last);
      req_type item;
      item.data_byte   = value;
      item.stream_last = last;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_data     <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      end_check    <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_reg(CSR_DIRECTION, {7'b0, DIR_ENCODE});
      write_reg(CSR_SUPPRESSED_BYTE, 8'h00);

      // full group with nothing suppressed, then short and single-byte streams
      foreach (dense_group[i]) begin
         send_item(dense_group[i], 1'b0);
      end
      send_item(8'h00, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'h00, 1'b1);
      send_item(8'h00, 1'b1);

      // marker changed part way through a group
      send_item(8'h12, 1'b0);
      send_item(8'h00, 1'b0);
      wait_idle();
      write_reg(CSR_SUPPRESSED_BYTE, 8'h12);
      send_item(8'h12, 1'b1);

      // open group abandoned by a direction write
      send_item(8'h34, 1'b0);
      send_item(8'h56, 1'b0);
      wait_idle();
      write_reg(CSR_DIRECTION, {7'b0, DIR_DECODE});

      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b1);
      send_item(8'hA0, 1'b0);
      send_item(8'h77, 1'b0);
      send_item(8'h99, 1'b1);
      send_item(8'h40, 1'b0);
      wait_idle();
      write_reg(CSR_DIRECTION, {7'b0, DIR_DECODE});
      send_item(8'hC0, 1'b1);

      for (int p = 0; p < 8; p++) begin
         wait_idle();
         mode = (p >= 4) ? DIR_DECODE : DIR_ENCODE;
         case (p)
            0, 5: mk = 8'h00;
            1, 4: mk = 8'hFF;
            3: mk = 8'h80;
            default: mk = 8'($urandom);
         endcase
         write_reg(CSR_DIRECTION, {7'($urandom), mode});
         write_reg(CSR_SUPPRESSED_BYTE, mk);
         send_idle_pct = idle_mix[p % 4];
         stall_pct     = stall_mix[p % 4];
         phase_end     = sent_count + 12;
         while (sent_count < phase_end) begin
            if ($urandom_range(9) < 2) begin
               len = $urandom_range(1, 6);
               for (int i = 0; i < len; i++) begin
                  send_item(8'($urandom), $urandom_range(7) == 0);
               end
            end else if (mode == DIR_ENCODE) begin
               len = $urandom_range(1, 20);
               for (int i = 0; i < len; i++) begin
                  send_item(($urandom_range(99) < 40) ? mk : 8'($urandom), i == len - 1);
               end
            end else begin
               groups = $urandom_range(1, 3);
               for (int g = 0; g < groups; g++) begin
                  case ($urandom_range(7))
                     0, 1: flag = 8'hFF;
                     2: flag = 8'h00;
                     default: flag = 8'($urandom);
                  endcase
                  zeros = 0;
                  for (int i = 0; i < 8; i++) begin
                     if (!flag[i]) zeros++;
                  end
                  closing = (g == groups - 1);
                  data_n  = (closing && $urandom_range(1)) ? $urandom_range(zeros) : zeros;
                  send_item(flag, closing && data_n == 0);
                  for (int i = 0; i < data_n; i++) begin
                     send_item(8'($urandom), closing && i == data_n - 1);
                  end
               end
            end
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      end_check <= 1'b1;
      repeat (2) @(posedge clock);
      if (check_failures == 0) begin
         $display("** zero_byte_suppression_codec_unit: PASSED **");
      end else begin
         $display("** zero_byte_suppression_codec_unit: FAILED **");
      end
      $finish;
   end

endmodule

`default_nettype wire
